/* rtl/nss_pkg.sv */
// ----------------------------------------------------------------------------
// Naive substring search package
// Shared constants, codes, state type and status structure of the search unit.
// ----------------------------------------------------------------------------
package nss_pkg;

   localparam int TEXT_DEPTH_DEFAULT    = 256;
   localparam int PATTERN_DEPTH_DEFAULT = 256;

   localparam int CHAR_W = 8;
   localparam int KIND_W = 2;
   localparam int POS_W  = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_TEXT    = 2'd0,
      KIND_PATTERN = 2'd1,
      KIND_SEARCH  = 2'd2,
      KIND_UNUSED  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic             found;
      logic [POS_W-1:0] position;
   } srch_status_type;

endpackage

/* rtl/nss_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/nss_search_ctrl.sv */
// ----------------------------------------------------------------------------
// Search sequencer
// Walks the start positions and pattern offsets, reading both stores and
// comparing one character pair per step with a single comparator.
// ----------------------------------------------------------------------------
module nss_search_ctrl #(
   parameter int TEXT_DEPTH    = nss_pkg::TEXT_DEPTH_DEFAULT,
   parameter int PATTERN_DEPTH = nss_pkg::PATTERN_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  out_free,
   input  logic [$clog2(TEXT_DEPTH+1)-1:0]       text_len,
   input  logic [$clog2(PATTERN_DEPTH+1)-1:0]    pattern_len,
   output logic [$clog2(TEXT_DEPTH)-1:0]         text_rd_addr,
   output logic [$clog2(PATTERN_DEPTH)-1:0]      pattern_rd_addr,
   input  logic [nss_pkg::CHAR_W-1:0]            text_rd_data,
   input  logic [nss_pkg::CHAR_W-1:0]            pattern_rd_data,
   output nss_pkg::srch_status_type              status
);

   localparam int TAW  = $clog2(TEXT_DEPTH);
   localparam int PAW  = $clog2(PATTERN_DEPTH);
   localparam int TLW  = $clog2(TEXT_DEPTH + 1);
   localparam int PLW  = $clog2(PATTERN_DEPTH + 1);
   localparam int LW   = ((TLW > PLW) ? TLW : PLW) + 1;
   localparam int EXTW = (TAW > nss_pkg::POS_W) ? TAW : nss_pkg::POS_W;

   nss_pkg::state_type state_ff, state_in;
   logic [TAW-1:0]     s_ff, s_in;
   logic [PAW-1:0]     k_ff, k_in;
   logic               found_ff, found_in;

   logic [LW-1:0]   tlen_x;
   logic [LW-1:0]   plen_x;
   logic            chars_equal;
   logic            last_offset;
   logic            last_start;
   logic            no_search;
   logic [EXTW-1:0] s_ext;

   assign tlen_x      = LW'(text_len);
   assign plen_x      = LW'(pattern_len);
   assign chars_equal = (text_rd_data == pattern_rd_data);
   assign last_offset = ((LW'(k_ff) + LW'(1)) == plen_x);
   assign last_start  = ((LW'(s_ff) + plen_x) == tlen_x);
   assign no_search   = (plen_x == '0) || (tlen_x == '0) || (plen_x > tlen_x);

   assign text_rd_addr    = TAW'(LW'(s_ff) + LW'(k_ff));
   assign pattern_rd_addr = k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff     <= s_in;
      k_ff     <= k_in;
      found_ff <= found_in;
   end

   always_comb begin
      state_in = state_ff;
      s_in     = s_ff;
      k_in     = k_ff;
      found_in = found_ff;
      unique case (state_ff)
         nss_pkg::ST_IDLE: begin
            if (start) begin
               s_in     = '0;
               k_in     = '0;
               found_in = 1'b0;
               state_in = no_search ? nss_pkg::ST_FINISH : nss_pkg::ST_READ;
            end
         end
         nss_pkg::ST_READ: begin
            state_in = nss_pkg::ST_CMP;
         end
         nss_pkg::ST_CMP: begin
            if (chars_equal && last_offset) begin
               found_in = 1'b1;
               state_in = nss_pkg::ST_FINISH;
            end else if (chars_equal) begin
               k_in     = k_ff + 1'b1;
               state_in = nss_pkg::ST_READ;
            end else if (last_start) begin
               s_in     = '0;
               state_in = nss_pkg::ST_FINISH;
            end else begin
               s_in     = s_ff + 1'b1;
               k_in     = '0;
               state_in = nss_pkg::ST_READ;
            end
         end
         nss_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = nss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nss_pkg::ST_IDLE;
         end
      endcase
   end

   assign s_ext           = EXTW'(s_ff);
   assign status.busy     = (state_ff != nss_pkg::ST_IDLE);
   assign status.done     = (state_ff == nss_pkg::ST_FINISH) && out_free;
   assign status.found    = found_ff;
   assign status.position = s_ext[nss_pkg::POS_W-1:0];

`ifndef NO_ASSERTIONS
   a_start_when_idle : assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == nss_pkg::ST_IDLE))
      else $error("search started while the sequencer was busy");

   a_offset_in_pattern : assert property (@(posedge clock) disable iff (reset)
      (state_ff == nss_pkg::ST_CMP) |-> (LW'(k_ff) < plen_x))
      else $error("pattern offset beyond pattern length");

   a_start_in_text : assert property (@(posedge clock) disable iff (reset)
      (state_ff == nss_pkg::ST_CMP) |-> ((LW'(s_ff) + plen_x) <= tlen_x))
      else $error("start position leaves the text");

   a_done_returns_idle : assert property (@(posedge clock) disable iff (reset)
      status.done |=> (state_ff == nss_pkg::ST_IDLE))
      else $error("sequencer did not return to idle after a result");

   a_miss_at_zero : assert property (@(posedge clock) disable iff (reset)
      (status.done && !status.found) |-> (s_ff == '0))
      else $error("miss reported with a nonzero position");
`endif

endmodule

/* rtl/naive_substring_search_unit.sv */
// ----------------------------------------------------------------------------
// Naive substring search unit
// Loads a text and a pattern one character at a time and reports the lowest
// start position at which the pattern occurs in the text.
// ----------------------------------------------------------------------------
// A text or pattern character transaction is taken while no search is busy,
// and a zero character or a character beyond the store depth is dropped. A
// search transaction holds the input off until its result is registered: each
// character pair compared passes through a read state and a compare state,
// because the stores have one registered read port each and a single
// comparator checks one pair per step, and the search ends in a finish state
// that waits until the output is free. After every search both lengths return
// to zero. Store contents are undefined after reset and only entries that
// have been written are ever compared, so no clearing pass is needed.
module naive_substring_search_unit #(
   parameter int TEXT_DEPTH    = nss_pkg::TEXT_DEPTH_DEFAULT,
   parameter int PATTERN_DEPTH = nss_pkg::PATTERN_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [nss_pkg::CHAR_W-1:0]   req_tdata,   // character
   input  logic [nss_pkg::KIND_W-1:0]   req_tuser,   // kind
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [nss_pkg::POS_W-1:0]    rsp_tdata,   // position
   output logic                         rsp_tuser    // found
);

   localparam int TAW = $clog2(TEXT_DEPTH);
   localparam int PAW = $clog2(PATTERN_DEPTH);
   localparam int TLW = $clog2(TEXT_DEPTH + 1);
   localparam int PLW = $clog2(PATTERN_DEPTH + 1);

   logic [TLW-1:0] tlen_ff, tlen_in;
   logic [PLW-1:0] plen_ff, plen_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_found_ff, rsp_found_in;
   logic [nss_pkg::POS_W-1:0] rsp_pos_ff, rsp_pos_in;

   logic                      accept;
   logic                      char_nonzero;
   logic                      text_wr;
   logic                      pattern_wr;
   logic                      search_start;
   logic                      out_free;
   logic [TAW-1:0]            text_rd_addr;
   logic [PAW-1:0]            pattern_rd_addr;
   logic [nss_pkg::CHAR_W-1:0] text_rd_data;
   logic [nss_pkg::CHAR_W-1:0] pattern_rd_data;
   nss_pkg::srch_status_type  status;

   assign req_tready   = !status.busy;
   assign accept       = req_tvalid && req_tready;
   assign char_nonzero = (req_tdata != '0);
   assign text_wr      = accept && (req_tuser == nss_pkg::KIND_TEXT) && char_nonzero &&
                         (tlen_ff < TLW'(TEXT_DEPTH));
   assign pattern_wr   = accept && (req_tuser == nss_pkg::KIND_PATTERN) && char_nonzero &&
                         (plen_ff < PLW'(PATTERN_DEPTH));
   assign search_start = accept && (req_tuser == nss_pkg::KIND_SEARCH);
   assign out_free     = !rsp_valid_ff || rsp_tready;

   nss_ram #(
      .WIDTH (nss_pkg::CHAR_W),
      .DEPTH (TEXT_DEPTH)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (text_wr),
      .wr_addr (tlen_ff[TAW-1:0]),
      .wr_data (req_tdata),
      .rd_addr (text_rd_addr),
      .rd_data (text_rd_data)
   );

   nss_ram #(
      .WIDTH (nss_pkg::CHAR_W),
      .DEPTH (PATTERN_DEPTH)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (pattern_wr),
      .wr_addr (plen_ff[PAW-1:0]),
      .wr_data (req_tdata),
      .rd_addr (pattern_rd_addr),
      .rd_data (pattern_rd_data)
   );

   nss_search_ctrl #(
      .TEXT_DEPTH    (TEXT_DEPTH),
      .PATTERN_DEPTH (PATTERN_DEPTH)
   ) u_search_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (search_start),
      .out_free        (out_free),
      .text_len        (tlen_ff),
      .pattern_len     (plen_ff),
      .text_rd_addr    (text_rd_addr),
      .pattern_rd_addr (pattern_rd_addr),
      .text_rd_data    (text_rd_data),
      .pattern_rd_data (pattern_rd_data),
      .status          (status)
   );

   always_comb begin
      tlen_in      = tlen_ff;
      plen_in      = plen_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      if (text_wr) begin
         tlen_in = tlen_ff + 1'b1;
      end
      if (pattern_wr) begin
         plen_in = plen_ff + 1'b1;
      end
      if (status.done) begin
         tlen_in      = '0;
         plen_in      = '0;
         rsp_valid_in = 1'b1;
         rsp_found_in = status.found;
         rsp_pos_in   = status.position;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlen_ff      <= '0;
         plen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tlen_ff      <= tlen_in;
         plen_ff      <= plen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pos_ff;
   assign rsp_tuser  = rsp_found_ff;

endmodule

/* bench/naive_substring_search_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Naive substring search unit testbench
// Streams text, pattern and search transactions into the unit and predicts
// every search result with a behavioural copy of the two stores and their
// lengths. Directed cases cover character extremes, dropped zero characters,
// the unused kind, empty strings and an over-long pattern. Random cases
// follow, including full stores and randomised flow control on both channels.
// ----------------------------------------------------------------------------
module naive_substring_search_unit_tb;

   localparam int TEXT_DEPTH    = nss_pkg::TEXT_DEPTH_DEFAULT;
   localparam int PATTERN_DEPTH = nss_pkg::PATTERN_DEPTH_DEFAULT;
   localparam int ITEM_TARGET   = 1750;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int HOLD_CYCLES   = 400;
   localparam int TAIL_CYCLES   = 50;

   typedef struct {
      nss_pkg::kind_type          kind;
      logic [nss_pkg::CHAR_W-1:0] ch;
      bit                         drain;
   } load_item_type;

   typedef struct {
      logic                      found;
      logic [nss_pkg::POS_W-1:0] position;
   } search_outcome_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [nss_pkg::CHAR_W-1:0] req_tdata  = '0;
   logic [nss_pkg::KIND_W-1:0] req_tuser  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [nss_pkg::POS_W-1:0]  rsp_tdata;
   logic                       rsp_tuser;

   load_item_type              pending_items[$];
   search_outcome_type         expected_outcomes[$];

   logic [nss_pkg::CHAR_W-1:0] text_chars [0:TEXT_DEPTH-1];
   logic [nss_pkg::CHAR_W-1:0] pattern_chars [0:PATTERN_DEPTH-1];
   int                         text_len    = 0;
   int                         pattern_len = 0;

   logic [nss_pkg::CHAR_W-1:0] text_buf [0:263];
   logic [nss_pkg::CHAR_W-1:0] pat_buf [0:263];

   int                load_count      = 0;
   int                total_requests  = 0;
   int                requests_taken  = 0;
   int                mismatches      = 0;
   int                cycle_count     = 0;
   int                hold_left       = 0;
   bit                hold_used       = 1'b0;
   bit                drain_mark      = 1'b0;
   bit                req_taken       = 1'b0;
   load_item_type     head_item;

   naive_substring_search_unit #(
      .TEXT_DEPTH    (TEXT_DEPTH),
      .PATTERN_DEPTH (PATTERN_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic int sender_idle_pct();
      if (requests_taken < total_requests / 3) return 30;
      if (requests_taken < (2 * total_requests) / 3) return 73;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (requests_taken < total_requests / 3) return 73;
      if (requests_taken < (2 * total_requests) / 3) return 30;
      return 0;
   endfunction

   // Updates the store copies and queues the outcome of a search transaction.
   task automatic track_search_item(input logic [nss_pkg::KIND_W-1:0] kind,
                                    input logic [nss_pkg::CHAR_W-1:0] ch);
      search_outcome_type outcome;
      int                 start;
      int                 k;
      bit                 whole;
      case (kind)
         nss_pkg::KIND_TEXT: begin
            if (ch != 0 && text_len < TEXT_DEPTH) begin
               text_chars[text_len] = ch;
               text_len++;
            end
         end
         nss_pkg::KIND_PATTERN: begin
            if (ch != 0 && pattern_len < PATTERN_DEPTH) begin
               pattern_chars[pattern_len] = ch;
               pattern_len++;
            end
         end
         nss_pkg::KIND_SEARCH: begin
            outcome.found    = 1'b0;
            outcome.position = '0;
            if (pattern_len != 0 && text_len != 0 && pattern_len <= text_len) begin
               for (start = 0; start + pattern_len <= text_len && !outcome.found;
                    start++) begin
                  whole = 1'b1;
                  for (k = 0; k < pattern_len; k++) begin
                     if (text_chars[start + k] != pattern_chars[k]) whole = 1'b0;
                  end
                  if (whole) begin
                     outcome.found    = 1'b1;
                     outcome.position = start[nss_pkg::POS_W-1:0];
                  end
               end
            end
            expected_outcomes.push_back(outcome);
            text_len    = 0;
            pattern_len = 0;
         end
         default: ;
      endcase
   endtask

   task automatic queue_request(input nss_pkg::kind_type kind,
                                input logic [nss_pkg::CHAR_W-1:0] ch);
      load_item_type item;
      item.kind  = kind;
      item.ch    = ch;
      item.drain = drain_mark;
      drain_mark = 1'b0;
      pending_items.push_back(item);
      if (kind == nss_pkg::KIND_SEARCH || (kind != nss_pkg::KIND_UNUSED && ch != 0)) begin
         load_count++;
      end
   endtask

   task automatic queue_noise(input int noise_pct);
      logic [nss_pkg::CHAR_W-1:0] ch;
      if ($urandom_range(99) < noise_pct) begin
         ch = $urandom_range(1) ? 8'h00 : nss_pkg::CHAR_W'($urandom_range(255));
         queue_request(nss_pkg::kind_type'($urandom_range(3)), ch);
      end
   endtask

   // Loads text_buf and pat_buf in either order, then asks for a search.
   task automatic queue_search_case(input int tlen, input int plen,
                                    input bit pattern_first, input int noise_pct);
      int pass;
      int i;
      for (pass = 0; pass < 2; pass++) begin
         if ((pass == 0) == pattern_first) begin
            for (i = 0; i < plen; i++) begin
               queue_request(nss_pkg::KIND_PATTERN, pat_buf[i]);
               queue_noise(noise_pct);
            end
         end else begin
            for (i = 0; i < tlen; i++) begin
               queue_request(nss_pkg::KIND_TEXT, text_buf[i]);
               queue_noise(noise_pct);
            end
         end
      end
      queue_request(nss_pkg::KIND_SEARCH, nss_pkg::CHAR_W'($urandom_range(255)));
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         if (pending_items.size() != 0 &&
             !(pending_items[0].drain && expected_outcomes.size() != 0) &&
             $urandom_range(99) >= sender_idle_pct()) begin
            head_item = pending_items.pop_front();
            req_tuser  <= head_item.kind;
            req_tdata  <= head_item.ch;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!hold_used && requests_taken >= (4 * total_requests) / 5) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_tready <= hold_left == 0 && $urandom_range(99) >= receiver_idle_pct();
      end
   end

   always @(posedge clock) begin
      search_outcome_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            track_search_item(req_tuser, req_tdata);
            requests_taken++;
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outcomes.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: search result transaction with no search pending", $time);
               mismatches++;
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_tuser !== want.found || rsp_tdata !== want.position) begin
                  if (mismatches < 10)
                     $display("%0t: expected found=%0b position=%0d, got found=%0b position=%0d",
                              $time, want.found, want.position, rsp_tuser, rsp_tdata);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("naive_substring_search_unit verification failed");
         $finish;
      end
   end

   initial begin
      int  i;
      int  tlen;
      int  plen;
      int  at;
      int  sel;
      bit  drain_placed;
      drain_placed = 1'b0;

      // Character extremes; the pattern sits at position one.
      queue_request(nss_pkg::KIND_TEXT, 8'h01);
      queue_request(nss_pkg::KIND_TEXT, 8'hFF);
      queue_request(nss_pkg::KIND_TEXT, 8'h01);
      queue_request(nss_pkg::KIND_PATTERN, 8'hFF);
      queue_request(nss_pkg::KIND_PATTERN, 8'h01);
      queue_request(nss_pkg::KIND_SEARCH, 8'h00);
      // A zero character and the unused kind leave both strings empty.
      queue_request(nss_pkg::KIND_TEXT, 8'h00);
      queue_request(nss_pkg::KIND_UNUSED, 8'hFF);
      queue_request(nss_pkg::KIND_SEARCH, 8'hFF);
      // Empty pattern.
      queue_request(nss_pkg::KIND_TEXT, 8'h41);
      queue_request(nss_pkg::KIND_SEARCH, 8'h00);
      // Empty text.
      queue_request(nss_pkg::KIND_PATTERN, 8'h41);
      queue_request(nss_pkg::KIND_SEARCH, 8'h00);
      // Pattern longer than the text.
      queue_request(nss_pkg::KIND_TEXT, 8'h41);
      queue_request(nss_pkg::KIND_PATTERN, 8'h41);
      queue_request(nss_pkg::KIND_PATTERN, 8'h41);
      queue_request(nss_pkg::KIND_SEARCH, 8'h00);
      // Match at the first position, with a dropped zero pattern character.
      queue_request(nss_pkg::KIND_TEXT, 8'h41);
      queue_request(nss_pkg::KIND_TEXT, 8'h42);
      queue_request(nss_pkg::KIND_PATTERN, 8'h00);
      queue_request(nss_pkg::KIND_PATTERN, 8'h41);
      queue_request(nss_pkg::KIND_SEARCH, 8'h00);
      // No match.
      queue_request(nss_pkg::KIND_TEXT, 8'h42);
      queue_request(nss_pkg::KIND_PATTERN, 8'h43);
      queue_request(nss_pkg::KIND_SEARCH, 8'h00);

      // Full text store, with the only match in the last entry.
      for (i = 0; i < 260; i++) text_buf[i] = (i == 255) ? 8'h7A : (i > 255 ? 8'h62 : 8'h61);
      pat_buf[0] = 8'h7A;
      queue_search_case(260, 1, 1'b0, 0);

      // Both stores full with identical contents, plus dropped extras.
      for (i = 0; i < 258; i++) text_buf[i] = nss_pkg::CHAR_W'(8'h61 + $urandom_range(2));
      for (i = 0; i < 257; i++) pat_buf[i] = (i < 256) ? text_buf[i] : 8'h63;
      queue_search_case(258, 257, 1'b1, 0);

      while (load_count < ITEM_TARGET) begin
         sel = $urandom_range(99);
         if (sel < 2) begin
            tlen = $urandom_range(200, 262);
            plen = $urandom_range(2, 6);
            for (i = 0; i < tlen; i++) begin
               text_buf[i] = nss_pkg::CHAR_W'(8'h61 + $urandom_range(2));
            end
            at = $urandom_range(0, 256 - plen);
            for (i = 0; i < plen; i++) pat_buf[i] = text_buf[at + i];
            queue_search_case(tlen, plen, 1'($urandom_range(1)), 0);
         end else if (sel < 8) begin
            tlen = $urandom_range(1) ? 0 : $urandom_range(1, 4);
            plen = tlen == 0 ? $urandom_range(0, 3) : 0;
            for (i = 0; i < 4; i++) begin
               text_buf[i] = nss_pkg::CHAR_W'($urandom_range(1, 255));
               pat_buf[i]  = nss_pkg::CHAR_W'($urandom_range(1, 255));
            end
            queue_search_case(tlen, plen, 1'($urandom_range(1)), 5);
         end else if (sel < 88) begin
            tlen = $urandom_range(1, 12);
            plen = $urandom_range(1, 5);
            for (i = 0; i < tlen; i++) begin
               text_buf[i] = ($urandom_range(9) == 0)
                             ? nss_pkg::CHAR_W'($urandom_range(1, 255))
                             : nss_pkg::CHAR_W'(8'h61 + $urandom_range(2));
            end
            if (plen <= tlen && $urandom_range(1)) begin
               at = $urandom_range(0, tlen - plen);
               for (i = 0; i < plen; i++) pat_buf[i] = text_buf[at + i];
            end else begin
               for (i = 0; i < plen; i++) begin
                  pat_buf[i] = nss_pkg::CHAR_W'(8'h61 + $urandom_range(2));
               end
            end
            queue_search_case(tlen, plen, $urandom_range(3) == 0, 4);
         end else begin
            for (i = $urandom_range(1, 6); i > 0; i--) begin
               queue_request(nss_pkg::kind_type'($urandom_range(3)),
                             nss_pkg::CHAR_W'($urandom_range(255)));
            end
         end
         if (!drain_placed && load_count >= ITEM_TARGET / 2) begin
            drain_placed = 1'b1;
            drain_mark   = 1'b1;
         end
      end
      total_requests = pending_items.size();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_outcomes.size() == 0) begin
         $display("naive_substring_search_unit verification clean");
      end else begin
         $display("naive_substring_search_unit verification failed");
      end
      $finish;
   end

endmodule
